[rtl/atsl_pkg.sv]
// ----------------------------------------------------------------------------
// atsl_pkg
// Types, constants and helpers shared by the address-to-symbol lookup block.
// ----------------------------------------------------------------------------
package atsl_pkg;

	localparam int TableDepth = 4096;
	localparam int IdxW = $clog2(TableDepth);
	localparam int CntW = IdxW + 1;
	localparam int HypercallSlots = 56;
	localparam logic [63:0] WindowBytes = 64'd4096;
	localparam logic [55:0] NamedMask = 56'hFF_007F_FD76_F7BF;

	localparam logic [7:0] KindTU = 8'h54;
	localparam logic [7:0] KindTL = 8'h74;
	localparam logic [7:0] KindWU = 8'h57;
	localparam logic [7:0] KindWL = 8'h77;

	typedef enum logic [0:0] {
		OP_INSERT = 1'b0,
		OP_LOOKUP = 1'b1
	} op_t;

	typedef enum logic [2:0] {
		ST_MATCH      = 3'd0,
		ST_BOUNDS     = 3'd1,
		ST_NOT_CODE   = 3'd2,
		ST_NO_BRACKET = 3'd3,
		ST_STORED     = 3'd4,
		ST_IGNORED    = 3'd5,
		ST_FULL       = 3'd6
	} status_t;

	typedef enum logic [1:0] {
		HC_NAMED    = 2'd0,
		HC_UNUSED   = 2'd1,
		HC_RANGE    = 2'd2,
		HC_NONE     = 2'd3
	} hclass_t;

	typedef enum logic [2:0] {
		REG_CODE_START      = 3'd0,
		REG_CODE_LIMIT      = 3'd1,
		REG_INIT_CODE_START = 3'd2,
		REG_INIT_CODE_LIMIT = 3'd3,
		REG_HYPERCALL_BASE  = 3'd4
	} reg_idx_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_SRCH_RD,
		S_SRCH_CMP,
		S_SHIFT_RD,
		S_SHIFT_WR,
		S_PUT,
		S_LK_RD0,
		S_LK_RD1,
		S_LK_CALC,
		S_HC,
		S_OUT
	} state_t;

	typedef struct packed {
		logic [63:0] address;
		logic [15:0] id;
		logic        mark;
	} entry_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [15:0] found_id;
		logic [63:0] offset;
		logic [63:0] span;
		logic [7:0]  hypercall_number;
		logic [1:0]  hypercall_class;
	} result_t;

	typedef struct packed {
		logic [0:0]  op;
		logic [63:0] address;
		logic [7:0]  symbol_kind;
		logic [15:0] symbol_id;
		logic        is_hypercall_entry;
	} request_t;

	function automatic logic [1:0] hc_class(input logic [58:0] nr);
		logic [1:0] c;
		c = HC_RANGE;
		if (nr < 59'(HypercallSlots)) begin
			c = NamedMask[nr[5:0]] ? HC_NAMED : HC_UNUSED;
		end
		return c;
	endfunction

endpackage

[rtl/atsl_if.sv]
// ----------------------------------------------------------------------------
// atsl_if
// Valid/ready channel carrying one payload of type T.
// ----------------------------------------------------------------------------
interface atsl_if #(parameter type T = logic) ();
	logic valid;
	logic ready;
	T     payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

[rtl/atsl_ram.sv]
// ----------------------------------------------------------------------------
// atsl_ram
// Single-port table memory with registered read data.
// ----------------------------------------------------------------------------
module atsl_ram #(
	parameter int Depth = 4096,
	parameter int Width = 81
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] addr,
	input  logic [Width-1:0]         wdata,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end
endmodule

[rtl/address_to_symbol_lookup.sv]
// ----------------------------------------------------------------------------
// address_to_symbol_lookup
// Sorted symbol table with insert and predecessor lookup.
// ----------------------------------------------------------------------------
// channel | dir | payload
// req     | in  | op, address, symbol_kind, symbol_id, is_hypercall_entry
// rsp     | out | status, found_id, offset, span, hypercall_number, hypercall_class
// cfg     | in  | cfg_we, cfg_index, cfg_wdata
//
// Lookup: binary search on the single RAM port, each probe a read then a compare.
// Insert: the search, then a read and a write for each entry moved up.
// One request at a time; req.ready is low until the result is taken.
// Reset empties the table at once (count cleared); no clearing pass.
module address_to_symbol_lookup (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [63:0] cfg_wdata,
	atsl_if.sink        req,
	atsl_if.source      rsp
);
	import atsl_pkg::*;

	state_t state_q, state_d;
	logic [63:0] code_start_q, code_limit_q, init_start_q, init_limit_q, hc_base_q;
	request_t    req_q;
	logic [CntW-1:0] count_q, lo_q, hi_q, ptr_q;
	entry_t      hold_q, before_q;
	result_t     res_q;
	logic        ram_we;
	logic [IdxW-1:0] ram_addr;
	entry_t      ram_wdata, ram_rdata;
	logic [CntW-1:0] mid;
	logic        kept, in_win, in_main, in_init, bounds_ok;

	assign mid = lo_q + ((hi_q - lo_q) >> 1);

	atsl_ram #(.Depth(TableDepth), .Width($bits(entry_t))) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.addr (ram_addr),
		.wdata(ram_wdata),
		.rdata(ram_rdata)
	);

	assign kept = (req_q.symbol_kind == KindTU) || (req_q.symbol_kind == KindTL) ||
		(req_q.symbol_kind == KindWU) || (req_q.symbol_kind == KindWL);
	assign in_win = (hc_base_q != '0) && (req_q.address >= hc_base_q) &&
		((req_q.address - hc_base_q) < WindowBytes);
	assign in_main = (req_q.address >= code_start_q) && (req_q.address < code_limit_q);
	assign in_init = (req_q.address >= init_start_q) && (req_q.address < init_limit_q);
	assign bounds_ok = (code_start_q != '0) && (code_limit_q != '0) &&
		(init_start_q != '0) && (init_limit_q != '0);

	assign req.ready = (state_q == S_IDLE);
	assign rsp.valid = (state_q == S_OUT);
	assign rsp.payload = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			code_start_q <= '0;
			code_limit_q <= '0;
			init_start_q <= '0;
			init_limit_q <= '0;
			hc_base_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_CODE_START:      code_start_q <= cfg_wdata;
				REG_CODE_LIMIT:      code_limit_q <= cfg_wdata;
				REG_INIT_CODE_START: init_start_q <= cfg_wdata;
				REG_INIT_CODE_LIMIT: init_limit_q <= cfg_wdata;
				REG_HYPERCALL_BASE:  hc_base_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: if (req.valid) state_d = S_SRCH_RD;
			S_SRCH_RD: begin
				priority if (req_q.op == OP_INSERT && !kept) state_d = S_OUT;
				else if (req_q.op == OP_INSERT && count_q >= CntW'(TableDepth)) state_d = S_OUT;
				else if (req_q.op == OP_LOOKUP && (!bounds_ok ||
					!(in_win || in_main || in_init))) state_d = S_OUT;
				else if (lo_q < hi_q) state_d = S_SRCH_CMP;
				else if (req_q.op == OP_INSERT) state_d = (ptr_q > lo_q) ? S_SHIFT_RD : S_PUT;
				else if (lo_q == '0 || lo_q >= count_q) state_d = S_OUT;
				else state_d = S_LK_RD0;
			end
			S_SRCH_CMP: state_d = S_SRCH_RD;
			S_SHIFT_RD: state_d = S_SHIFT_WR;
			S_SHIFT_WR: state_d = (ptr_q - 1'b1 > lo_q) ? S_SHIFT_RD : S_PUT;
			S_PUT: state_d = S_OUT;
			S_LK_RD0: state_d = S_LK_RD1;
			S_LK_RD1: state_d = S_LK_CALC;
			S_LK_CALC: state_d = S_HC;
			S_HC: state_d = S_OUT;
			S_OUT: if (rsp.ready) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// RAM port control
	always_comb begin
		ram_we = 1'b0;
		ram_addr = mid[IdxW-1:0];
		ram_wdata = hold_q;
		unique case (state_q)
			S_SHIFT_RD: ram_addr = IdxW'(ptr_q - 1'b1);
			S_SHIFT_WR: begin
				ram_we = 1'b1;
				ram_addr = ptr_q[IdxW-1:0];
				ram_wdata = ram_rdata;
			end
			S_PUT: begin
				ram_we = 1'b1;
				ram_addr = lo_q[IdxW-1:0];
				ram_wdata = hold_q;
			end
			S_LK_RD0: ram_addr = IdxW'(lo_q - 1'b1);
			S_LK_RD1: ram_addr = lo_q[IdxW-1:0];
			default: ram_addr = mid[IdxW-1:0];
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == S_PUT) count_q <= count_q + 1'b1;
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				req_q <= req.payload;
				hold_q <= '{address: req.payload.address, id: req.payload.symbol_id,
					mark: req.payload.is_hypercall_entry};
				lo_q <= '0;
				hi_q <= count_q;
				ptr_q <= count_q;
				res_q <= '{status: ST_MATCH, found_id: '0, offset: '0, span: '0,
					hypercall_number: '0, hypercall_class: HC_NONE};
			end
			S_SRCH_RD: begin
				priority if (req_q.op == OP_INSERT && !kept) res_q.status <= ST_IGNORED;
				else if (req_q.op == OP_INSERT && count_q >= CntW'(TableDepth))
					res_q.status <= ST_FULL;
				else if (req_q.op == OP_LOOKUP && !bounds_ok) res_q.status <= ST_BOUNDS;
				else if (req_q.op == OP_LOOKUP && !(in_win || in_main || in_init))
					res_q.status <= ST_NOT_CODE;
				else if (lo_q < hi_q) ;
				else if (req_q.op == OP_INSERT) res_q.status <= ST_STORED;
				else if (lo_q == '0 || lo_q >= count_q) res_q.status <= ST_NO_BRACKET;
				else ;
			end
			S_SRCH_CMP: begin
				if (ram_rdata.address > req_q.address) hi_q <= mid;
				else lo_q <= mid + 1'b1;
			end
			S_SHIFT_WR: ptr_q <= ptr_q - 1'b1;
			S_LK_RD1: before_q <= ram_rdata;
			S_LK_CALC: begin
				res_q.found_id <= before_q.id;
				res_q.offset <= req_q.address - before_q.address;
				res_q.span <= ram_rdata.address - before_q.address;
			end
			S_HC: begin
				if (before_q.mark) begin
					res_q.hypercall_number <= (res_q.offset[63:5] > 59'd255) ? 8'd255 :
						res_q.offset[12:5];
					res_q.hypercall_class <= hc_class(res_q.offset[63:5]);
				end
			end
			default: ;
		endcase
	end
endmodule

[rtl/atsl_checker.sv]
// ----------------------------------------------------------------------------
// atsl_checker
// Port-level checks for the address-to-symbol lookup block.
// ----------------------------------------------------------------------------
module atsl_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        req_valid,
	input logic        req_ready,
	input logic        rsp_valid,
	input logic        rsp_ready,
	input logic [2:0]  rsp_status,
	input logic [1:0]  rsp_class,
	input logic [7:0]  rsp_number
);
	import atsl_pkg::*;

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		!(req_ready && rsp_valid)) else $error("request taken while result pending");
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready) else $error("ready after accept");
	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp_status <= ST_FULL) else $error("bad status");
	a_no_data: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_status != ST_MATCH |-> rsp_class == HC_NONE && rsp_number == '0)
		else $error("lookup data on a non-match");
	// hold the result until it is taken
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) &&
		$stable(rsp_class) && $stable(rsp_number)) else $error("result dropped or changed");
endmodule

bind address_to_symbol_lookup atsl_checker u_atsl_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req.valid),
	.req_ready (req.ready),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.rsp_status(rsp.payload.status),
	.rsp_class (rsp.payload.hypercall_class),
	.rsp_number(rsp.payload.hypercall_number)
);

[tb/atsl_result_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// atsl_result_checker
// Watches the request, result and register ports of the symbol lookup block.
// Keeps its own sorted symbol table and region registers, works out the
// answer to every accepted request and compares each result in arrival order.
// ----------------------------------------------------------------------------
module atsl_result_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [63:0]        cfg_wdata,
	input  logic               req_valid,
	input  logic               req_ready,
	input  atsl_pkg::request_t req_payload,
	input  logic               rsp_valid,
	input  logic               rsp_ready,
	input  atsl_pkg::result_t  rsp_payload,
	output int                 mismatches,
	output int                 awaiting
);
	import atsl_pkg::*;

	logic [63:0] code_lo, code_hi, init_lo, init_hi, hc_base;
	entry_t      symtab[$];
	result_t     answers_due[$];

	// index of the first entry whose address lies strictly above a
	function automatic int first_above(input logic [63:0] a);
		int lo;
		int hi;
		int mid;
		lo = 0;
		hi = symtab.size();
		while (lo < hi) begin
			mid = lo + (hi - lo) / 2;
			if (symtab[mid].address > a) hi = mid;
			else lo = mid + 1;
		end
		return lo;
	endfunction

	function automatic logic is_code(input logic [63:0] a);
		if (hc_base != 0 && a >= hc_base && a - hc_base < WindowBytes) return 1'b1;
		if (a >= code_lo && a < code_hi) return 1'b1;
		if (a >= init_lo && a < init_hi) return 1'b1;
		return 1'b0;
	endfunction

	function automatic result_t resolve_request(input request_t r);
		result_t     res;
		int          pos;
		entry_t      e;
		logic [58:0] nr;
		res = '0;
		res.hypercall_class = HC_NONE;
		if (op_t'(r.op) == OP_INSERT) begin
			if (!(r.symbol_kind inside {KindTU, KindTL, KindWU, KindWL})) begin
				res.status = ST_IGNORED;
			end else if (symtab.size() >= TableDepth) begin
				res.status = ST_FULL;
			end else begin
				pos = first_above(r.address);
				e.address = r.address;
				e.id = r.symbol_id;
				e.mark = r.is_hypercall_entry;
				symtab.insert(pos, e);
				res.status = ST_STORED;
			end
		end else if (code_lo == 0 || code_hi == 0 || init_lo == 0 || init_hi == 0) begin
			res.status = ST_BOUNDS;
		end else if (!is_code(r.address)) begin
			res.status = ST_NOT_CODE;
		end else begin
			pos = first_above(r.address);
			if (pos == 0 || pos >= symtab.size()) begin
				res.status = ST_NO_BRACKET;
			end else begin
				res.status = ST_MATCH;
				res.found_id = symtab[pos-1].id;
				res.offset = r.address - symtab[pos-1].address;
				res.span = symtab[pos].address - symtab[pos-1].address;
				if (symtab[pos-1].mark) begin
					nr = res.offset[63:5];
					res.hypercall_number = (nr > 255) ? 8'd255 : nr[7:0];
					if (nr >= HypercallSlots) res.hypercall_class = HC_RANGE;
					else if (NamedMask[nr[5:0]]) res.hypercall_class = HC_NAMED;
					else res.hypercall_class = HC_UNUSED;
				end
			end
		end
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			code_lo = '0;
			code_hi = '0;
			init_lo = '0;
			init_hi = '0;
			hc_base = '0;
			symtab.delete();
			answers_due.delete();
			mismatches = 0;
			awaiting = 0;
		end else begin
			// retire the result first: the next request may share this edge
			if (rsp_valid && rsp_ready) begin
				if (answers_due.size() == 0) begin
					mismatches++;
					if (mismatches <= 10) $display("%0t: result with no request pending", $realtime);
				end else begin
					want = answers_due.pop_front();
					if (rsp_payload !== want) begin
						mismatches++;
						if (mismatches <= 10) begin
							$display("%0t: result mismatch", $realtime);
							$display("  status   exp %0d got %0d", want.status, rsp_payload.status);
							$display("  found_id exp %h got %h", want.found_id, rsp_payload.found_id);
							$display("  offset   exp %h got %h", want.offset, rsp_payload.offset);
							$display("  span     exp %h got %h", want.span, rsp_payload.span);
							$display("  hc_num   exp %0d got %0d", want.hypercall_number,
								rsp_payload.hypercall_number);
							$display("  hc_class exp %0d got %0d", want.hypercall_class,
								rsp_payload.hypercall_class);
						end
					end
				end
			end
			if (req_valid && req_ready)
				answers_due.insert(answers_due.size(), resolve_request(req_payload));
			if (cfg_we) begin
				case (cfg_index)
					REG_CODE_START:      code_lo = cfg_wdata;
					REG_CODE_LIMIT:      code_hi = cfg_wdata;
					REG_INIT_CODE_START: init_lo = cfg_wdata;
					REG_INIT_CODE_LIMIT: init_hi = cfg_wdata;
					REG_HYPERCALL_BASE:  hc_base = cfg_wdata;
					default: ;
				endcase
			end
			awaiting = answers_due.size();
		end
	end

endmodule

[tb/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Drives inserts and lookups into the symbol lookup block under several
// region settings, with random gaps and result stalls; the checker beside
// the block predicts every result and counts mismatches.
// ----------------------------------------------------------------------------
module tb_top;
	import atsl_pkg::*;

	localparam logic [2:0]  RegSpare = 3'd7;
	localparam logic [63:0] AllOnes = '1;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [2:0]  cfg_index;
	logic [63:0] cfg_wdata;
	logic        calm;
	int          mismatches;
	int          awaiting;
	int          kept;
	logic [63:0] placed[$];
	logic [63:0] cur_code, cur_init, cur_hc;

	atsl_if #(.T(request_t)) req_ch ();
	atsl_if #(.T(result_t))  rsp_ch ();

	address_to_symbol_lookup i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.req       (req_ch),
		.rsp       (rsp_ch)
	);

	atsl_result_checker i_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_wdata   (cfg_wdata),
		.req_valid   (req_ch.valid),
		.req_ready   (req_ch.ready),
		.req_payload (req_ch.payload),
		.rsp_valid   (rsp_ch.valid),
		.rsp_ready   (rsp_ch.ready),
		.rsp_payload (rsp_ch.payload),
		.mismatches  (mismatches),
		.awaiting    (awaiting)
	);

	initial clk = 1'b0;
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
		end else begin
			rsp_ch.ready <= calm || ($urandom_range(99) >= 24);
		end
	end

	initial begin
		#(12 * 3000000);
		$display("simulation failed");
		$finish;
	end

	task automatic put_reg(input logic [2:0] idx, input logic [63:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
	endtask

	task automatic program_regions(input logic [63:0] cs, cl, ics, icl, hb);
		put_reg(REG_CODE_START, cs);
		put_reg(REG_CODE_LIMIT, cl);
		put_reg(REG_INIT_CODE_START, ics);
		put_reg(REG_INIT_CODE_LIMIT, icl);
		put_reg(REG_HYPERCALL_BASE, hb);
		// unknown index must leave every register alone
		put_reg(RegSpare, {$urandom, $urandom});
		cfg_we <= 1'b0;
		@(posedge clk);
		cur_code = cs;
		cur_init = ics;
		cur_hc = hb;
	endtask

	// drop valid, then wait until every request has its result
	task automatic settle();
		req_ch.valid <= 1'b0;
		do @(negedge clk); while (awaiting != 0);
		repeat (40) @(posedge clk);
	endtask

	task automatic send(input op_t op, input logic [63:0] a, input logic [7:0] kind,
			input logic [15:0] id, input logic mark);
		request_t r;
		r.op = op;
		r.address = a;
		r.symbol_kind = kind;
		r.symbol_id = id;
		r.is_hypercall_entry = mark;
		if (!calm && $urandom_range(99) < 24) begin
			req_ch.valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < 24);
		end
		req_ch.valid <= 1'b1;
		req_ch.payload <= r;
		do @(posedge clk); while (!req_ch.ready);
		if (op == OP_INSERT && kind inside {KindTU, KindTL, KindWU, KindWL} && kept < TableDepth) begin
			kept++;
			placed.insert(placed.size(), a);
		end
	endtask

	function automatic logic [63:0] pick_address();
		logic [63:0] a;
		case ($urandom_range(19))
			0, 1, 2, 3, 4, 5: begin
				a = placed.size() ? placed[$urandom_range(placed.size() - 1)] : cur_code;
				a = $urandom_range(1) ? a + $urandom_range(16'h2000) : a - $urandom_range(3);
			end
			6, 7, 8:    a = cur_hc + $urandom_range(16'h1FFF);
			9, 10, 11:  a = cur_code + $urandom_range(20'hFFFFF);
			12, 13:     a = cur_init + $urandom_range(16'hFFFF);
			14, 15:     a = {$urandom, $urandom};
			16:         a = $urandom_range(1) ? '0 : AllOnes;
			default:    a = 64'h1000_0000 + $urandom_range(24'h10_0000);
		endcase
		return a;
	endfunction

	function automatic logic [7:0] pick_kind();
		case ($urandom_range(9))
			0, 1: return 8'($urandom);
			2, 3: return KindTU;
			4, 5: return KindTL;
			6, 7: return KindWU;
			default: return KindWL;
		endcase
	endfunction

	task automatic random_traffic(input int n);
		repeat (n) begin
			if ($urandom_range(99) < 20) begin
				send(OP_INSERT, pick_address(), pick_kind(), 16'($urandom),
					$urandom_range(99) < 25);
			end else begin
				send(OP_LOOKUP, pick_address(), 8'($urandom), 16'($urandom), 1'($urandom));
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		calm = 1'b0;
		kept = 0;
		cur_code = 64'h1000_0000;
		cur_init = 64'h0800_0000;
		cur_hc = 64'h3000_0000;
		cfg_we <= 1'b0;
		cfg_index <= '0;
		cfg_wdata <= '0;
		req_ch.valid <= 1'b0;
		req_ch.payload <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// bounds still unknown, ignored letters
		send(OP_LOOKUP, 64'h1000_0000, 8'h00, 16'h0000, 1'b0);
		send(OP_INSERT, 64'h1000_0000, 8'h00, 16'hFFFF, 1'b1);
		send(OP_INSERT, AllOnes, 8'hFF, 16'h0000, 1'b0);
		settle();
		program_regions(64'h1000_0000, 64'h1010_0000, 64'h0800_0000, 64'h0800_1000,
			64'h3000_0000);
		// empty table
		send(OP_LOOKUP, 64'h1000_0010, KindTU, 16'h0, 1'b0);
		send(OP_INSERT, 64'h1000_0000, KindWU, 16'h1234, 1'b0);
		send(OP_INSERT, 64'h1000_0000, KindWL, 16'h4321, 1'b0);
		send(OP_INSERT, 64'h3000_0000, KindTU, 16'hA5A5, 1'b1);
		send(OP_INSERT, 64'h3000_1000, KindTL, 16'h5A5A, 1'b0);
		send(OP_LOOKUP, 64'h1000_0000, 8'h0, 16'h0, 1'b0);
		send(OP_LOOKUP, 64'h0FFF_FFFF, 8'h0, 16'h0, 1'b0);
		send(OP_LOOKUP, 64'h3000_0000, 8'h0, 16'h0, 1'b0);
		send(OP_LOOKUP, 64'h3000_0000 + 6 * 32, 8'h0, 16'h0, 1'b0);
		send(OP_LOOKUP, 64'h3000_0000 + 56 * 32, 8'h0, 16'h0, 1'b0);
		send(OP_LOOKUP, 64'h3000_0FFF, 8'h0, 16'h0, 1'b0);
		send(OP_LOOKUP, 64'h3000_1000, 8'h0, 16'h0, 1'b0);
		send(OP_LOOKUP, 64'h0000_0005, 8'h0, 16'h0, 1'b0);
		// extreme addresses and ids, then a wide marked entry for saturation
		send(OP_INSERT, 64'h0, KindTU, 16'h0000, 1'b0);
		send(OP_INSERT, AllOnes, KindTL, 16'hFFFF, 1'b1);
		send(OP_INSERT, 64'h1008_0000, KindWU, 16'h7777, 1'b1);
		send(OP_LOOKUP, 64'h1008_3000, 8'h0, 16'h0, 1'b0);
		send(OP_LOOKUP, 64'h0800_0010, 8'h0, 16'h0, 1'b0);
		settle();

		random_traffic(350);
		settle();
		// whole space is code except address zero and the top address; window off, init empty
		calm = 1'b1;
		program_regions(64'h1, AllOnes, 64'h0800_0000, 64'h0800_0000, 64'h0);
		random_traffic(350);
		send(OP_LOOKUP, AllOnes, 8'h0, 16'h0, 1'b0);
		send(OP_LOOKUP, AllOnes - 1, 8'h0, 16'h0, 1'b0);
		settle();
		calm = 1'b0;
		// window at the top of the space, init limit below its start
		program_regions(64'h1000_0000, 64'h1000_8000, 64'h2000_0000, 64'h1000_0000,
			64'hFFFF_FFFF_FFFF_F000);
		send(OP_INSERT, 64'hFFFF_FFFF_FFFF_F000, KindWL, 16'hBEEF, 1'b1);
		random_traffic(350);
		settle();
		program_regions(64'h1000_0000, 64'h1010_0000, 64'h0800_0000, 64'h0, 64'h3000_0000);
		random_traffic(150);
		settle();
		program_regions(AllOnes, AllOnes, 64'h0800_0000, 64'h1010_0000, 64'h1000_8000);
		random_traffic(550);
		settle();

		// a last marked insert, an ignored letter and a lookup
		send(OP_INSERT, 64'h1000_0000, KindWU, 16'h1111, 1'b1);
		send(OP_INSERT, 64'h1000_0000, 8'h41, 16'h2222, 1'b0);
		send(OP_LOOKUP, 64'h1000_0040, 8'h0, 16'h0, 1'b0);
		random_traffic(40);
		settle();

		if (mismatches == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
